// ===== design/accid_pkg.sv =====
// ----------------------------------------------------------------------------
// Accessory ID detector package
// Shared types and fixed constants for the accessory ID detector.
// ----------------------------------------------------------------------------
package accid_pkg;

    localparam int ADC_W   = 12;
    localparam int ADC_MAX = (1 << ADC_W) - 1;

    // item kinds on the input channel
    localparam logic CMD_PIN = 1'b0;
    localparam logic CMD_ADC = 1'b1;

    // accepted pin level, with a third code for "not known yet"
    localparam logic [1:0] LEVEL_UNKNOWN = 2'd3;

    // configuration register map
    localparam logic [1:0]  ADDR_DEBOUNCE  = 2'd0;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd10;

    typedef enum logic [2:0] {
        ACC_UNKNOWN   = 3'd0,
        ACC_OTG       = 3'd1,
        ACC_TV_OUT    = 3'd2,
        ACC_LINEOUT   = 3'd3,
        ACC_CAR_MOUNT = 3'd4
    } acc_t;

    // classification windows, both bounds exclusive
    localparam logic [ADC_W-1:0] OTG_LO     = 12'd2600;
    localparam logic [ADC_W-1:0] OTG_HI     = 12'd2860;
    localparam logic [ADC_W-1:0] TV_LO      = 12'd2110;
    localparam logic [ADC_W-1:0] TV_HI      = 12'd2360;
    localparam logic [ADC_W-1:0] CAR_LO     = 12'd1590;
    localparam logic [ADC_W-1:0] CAR_HI     = 12'd1840;
    localparam logic [ADC_W-1:0] LINEOUT_LO = 12'd1100;
    localparam logic [ADC_W-1:0] LINEOUT_HI = 12'd1360;

endpackage

// ===== design/accessory_id_detector_core.sv =====
// ----------------------------------------------------------------------------
// Accessory ID detector core
// Debounces the ID pin, measures the ID voltage with a trimmed mean and
// reports accessory attach and removal events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries pin samples (cmd = 0) and
//   converter samples (cmd = 1). A pin change must repeat for debounce_count
//   samples. An accepted detach reports the stored accessory offline; an
//   accepted attach collects SAMPLE_COUNT converter samples, drops the
//   largest and smallest, averages the rest and reports the matching
//   accessory online, or a removal on a zero mean. Most transfers give no result.
//   Output channel (out_valid/out_ready) carries accessory, online and
//   measured_level.
//   Timing: a transfer lands in the input register, is evaluated
//   combinationally and its result (if any) is registered in the output
//   register, from which it is taken when out_ready is high. One item per
//   cycle is taken while no result is stalled; the rate is set by the single
//   evaluation stage that updates the debounce and measurement state.
//   Stall: while a result waits on out_ready, one more item is held in the
//   input register and then in_ready drops.
//   Reset: level unknown, no accessory stored, debounce_count = 10.
//   debounce_count lives at APB address 0; write it only while idle.
// ----------------------------------------------------------------------------
module accessory_id_detector_core #(
    parameter int SAMPLE_COUNT = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        pin_level,
    input  logic [11:0] adc_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  accessory,
    output logic        online,
    output logic [11:0] measured_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import accid_pkg::*;

    localparam int SUM_W  = $clog2(SAMPLE_COUNT*ADC_MAX+1);
    localparam int TRIM_W = $clog2((SAMPLE_COUNT-2)*ADC_MAX+1);
    localparam int IDX_W  = $clog2(SAMPLE_COUNT+1);

    // configuration
    logic [7:0] debounce_reg;

    // input stage
    logic             in_valid_reg;
    logic             cmd_reg;
    logic             pin_reg;
    logic [ADC_W-1:0] adc_reg;
    logic             advance;

    // detector state
    logic [1:0]       accepted_reg, accepted_next;
    logic [7:0]       stable_reg, stable_next;
    logic             cand_reg, cand_next;
    logic             measuring_reg, measuring_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [ADC_W-1:0] min_reg, min_next;
    logic [ADC_W-1:0] max_reg, max_next;
    acc_t             present_reg, present_next;

    // output stage
    logic             out_valid_reg;
    acc_t             accessory_reg;
    logic             online_reg;
    logic [ADC_W-1:0] level_reg;

    // evaluation
    logic [7:0]        need;
    logic [7:0]        run_cnt;
    logic              first_sample;
    logic [ADC_W-1:0]  min_new;
    logic [ADC_W-1:0]  max_new;
    logic [SUM_W-1:0]  sum_new;
    logic [IDX_W-1:0]  idx_inc;
    logic              last_sample;
    logic [TRIM_W-1:0] trimmed;
    logic [ADC_W-1:0]  mean;
    acc_t              mean_acc;
    logic              res_fire;
    acc_t              res_acc;
    logic              res_online;
    logic [ADC_W-1:0]  res_level;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DEBOUNCE) ? {24'd0, debounce_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_reg <= DEBOUNCE_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_DEBOUNCE)
            debounce_reg <= pwdata[7:0];
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            pin_reg <= pin_level;
            adc_reg <= adc_sample;
        end
    end

    // ------------------------------------------------------------------
    // running measurement
    // ------------------------------------------------------------------
    assign first_sample = (idx_reg == '0);
    assign max_new      = (first_sample || adc_reg > max_reg) ? adc_reg : max_reg;
    assign min_new      = (first_sample || adc_reg < min_reg) ? adc_reg : min_reg;
    assign sum_new      = sum_reg + SUM_W'(adc_reg);
    assign idx_inc      = idx_reg + IDX_W'(1);
    assign last_sample  = (idx_inc == IDX_W'(SAMPLE_COUNT));
    assign trimmed      = TRIM_W'(sum_new - SUM_W'(max_new) - SUM_W'(min_new));

    accid_classify #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_classify (
        .trimmed(trimmed),
        .mean   (mean),
        .acc    (mean_acc)
    );

    // ------------------------------------------------------------------
    // next state and result
    // ------------------------------------------------------------------
    assign need = (debounce_reg == 8'd0) ? 8'd1 : debounce_reg;

    always_comb
    begin
        accepted_next  = accepted_reg;
        stable_next    = stable_reg;
        cand_next      = cand_reg;
        measuring_next = measuring_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        present_next   = present_reg;
        run_cnt        = 8'd1;
        res_fire       = 1'b0;
        res_acc        = present_reg;
        res_online     = 1'b0;
        res_level      = '0;

        if (advance)
        begin
            if (cmd_reg == CMD_PIN)
            begin
                // pin samples are dropped while a measurement runs
                if (!measuring_reg)
                begin
                    if ({1'b0, pin_reg} == accepted_reg)
                        stable_next = 8'd0;
                    else
                    begin
                        if (stable_reg == 8'd0 || pin_reg != cand_reg)
                            run_cnt = 8'd1;
                        else if (stable_reg != 8'hFF)
                            run_cnt = stable_reg + 8'd1;
                        else
                            run_cnt = stable_reg;
                        cand_next = pin_reg;

                        if (run_cnt < need)
                            stable_next = run_cnt;
                        else
                        begin
                            accepted_next = {1'b0, pin_reg};
                            stable_next   = 8'd0;
                            if (pin_reg)
                            begin
                                res_fire     = 1'b1;
                                res_acc      = present_reg;
                                present_next = ACC_UNKNOWN;
                            end
                            else
                            begin
                                measuring_next = 1'b1;
                                idx_next       = '0;
                                sum_next       = '0;
                                min_next       = '0;
                                max_next       = '0;
                            end
                        end
                    end
                end
            end
            else if (measuring_reg)
            begin
                sum_next = sum_new;
                min_next = min_new;
                max_next = max_new;
                idx_next = idx_inc;
                if (last_sample)
                begin
                    measuring_next = 1'b0;
                    idx_next       = '0;
                    if (mean == '0)
                    begin
                        // zero mean reads as a removal
                        res_fire     = 1'b1;
                        res_acc      = present_reg;
                        present_next = ACC_UNKNOWN;
                    end
                    else if (mean_acc != ACC_UNKNOWN)
                    begin
                        res_fire     = 1'b1;
                        res_acc      = mean_acc;
                        res_online   = 1'b1;
                        res_level    = mean;
                        present_next = mean_acc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg  <= LEVEL_UNKNOWN;
            stable_reg    <= 8'd0;
            cand_reg      <= 1'b0;
            measuring_reg <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            present_reg   <= ACC_UNKNOWN;
        end
        else
        begin
            accepted_reg  <= accepted_next;
            stable_reg    <= stable_next;
            cand_reg      <= cand_next;
            measuring_reg <= measuring_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            present_reg   <= present_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_fire;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
        begin
            accessory_reg <= res_acc;
            online_reg    <= res_online;
            level_reg     <= res_level;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accessory      = accessory_reg;
    assign online         = online_reg;
    assign measured_level = level_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        measuring_reg |-> idx_reg < IDX_W'(SAMPLE_COUNT))
        else $error("sample index past sample count");

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !measuring_reg |-> idx_reg == '0)
        else $error("sample index not cleared outside a measurement");

    a_online_classified: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && online_reg) |->
            (accessory_reg != ACC_UNKNOWN && level_reg != '0))
        else $error("online report without a classified accessory");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |=>
            (in_valid_reg && $stable(cmd_reg) && $stable(adc_reg)))
        else $error("input register lost an item during a stall");

endmodule

// ===== design/accid_classify.sv =====
// ----------------------------------------------------------------------------
// Accessory ID classifier
// Turns the trimmed sample sum into a mean and matches it against the
// accessory voltage windows.
// ----------------------------------------------------------------------------
module accid_classify #(
    parameter int SAMPLE_COUNT = 5
) (
    input  logic [$clog2((SAMPLE_COUNT-2)*accid_pkg::ADC_MAX+1)-1:0] trimmed,
    output logic [accid_pkg::ADC_W-1:0]                              mean,
    output accid_pkg::acc_t                                          acc
);
    import accid_pkg::*;

    localparam int DIVISOR  = SAMPLE_COUNT - 2;
    localparam int TRIM_W   = $clog2(DIVISOR*ADC_MAX+1);
    localparam int SHIFT_L  = $clog2(DIVISOR);
    localparam int SHIFT    = TRIM_W + SHIFT_L;
    // ceil(2^SHIFT / DIVISOR): exact quotient for every TRIM_W-bit dividend
    localparam int RECIP    = ((1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W   = SHIFT + ADC_W + 1;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(trimmed) * PROD_W'(RECIP);
    assign mean = prod[SHIFT +: ADC_W];

    always_comb
    begin
        if (mean > OTG_LO && mean < OTG_HI)
            acc = ACC_OTG;
        else if (mean > TV_LO && mean < TV_HI)
            acc = ACC_TV_OUT;
        else if (mean > CAR_LO && mean < CAR_HI)
            acc = ACC_CAR_MOUNT;
        else if (mean > LINEOUT_LO && mean < LINEOUT_HI)
            acc = ACC_LINEOUT;
        else
            acc = ACC_UNKNOWN;
    end

endmodule
